// File: rtl/assert_macros.svh
// assertion helpers, clocked on the rising edge and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/hidups_pkg.sv
`default_nettype none

package hidups_pkg;

    localparam int unsigned PageWidth = 16;
    localparam int unsigned ValueWidth = 32;

    localparam logic [7:0] LONG_PREFIX = 8'hFE;
    localparam logic [7:0] SIZE_MASK = 8'h03;
    localparam logic [7:0] TAG_MASK = 8'hFC;
    localparam logic [7:0] PAGE_TAG = 8'h04;
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

    typedef enum logic [2:0] {
        PH_PREFIX     = 3'd0,
        PH_LONG_SIZE  = 3'd1,
        PH_LONG_TAG   = 3'd2,
        PH_LONG_DATA  = 3'd3,
        PH_SHORT_DATA = 3'd4
    } parse_phase_t;

    typedef struct packed {
        logic       take;
        logic       last;
        logic [7:0] data;
    } parse_in_t;

endpackage

`default_nettype wire

// File: rtl/hidups_parse.sv
`default_nettype none

`include "assert_macros.svh"

module hidups_parse (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire hidups_pkg::parse_in_t         word_in,
    input  wire logic [hidups_pkg::PageWidth-1:0] usage_page,
    output logic                               found_now
);
    import hidups_pkg::*;

    parse_phase_t          phase_reg, phase_next;
    logic [7:0]            left_reg, left_next;
    logic [2:0]            len_reg, len_next;
    logic [1:0]            pos_reg, pos_next;
    logic [ValueWidth-1:0] value_reg, value_next;
    logic                  page_reg, page_next;
    logic                  found_reg, found_next;

    always_comb begin
        logic [2:0]            len_dec;
        logic [ValueWidth-1:0] value_acc;

        phase_next = phase_reg;
        left_next  = left_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        value_next = value_reg;
        page_next  = page_reg;
        found_next = found_reg;
        len_dec    = len_reg - 3'd1;
        value_acc  = value_reg
                   | ({{(ValueWidth-8){1'b0}}, word_in.data} << {pos_reg, 3'b000});

        unique case (phase_reg)
            PH_PREFIX: begin
                if (word_in.data == LONG_PREFIX) begin
                    phase_next = PH_LONG_SIZE;
                end else begin
                    pos_next   = 2'd0;
                    value_next = '0;
                    if ((word_in.data & SIZE_MASK) == 8'h00) begin
                        // zero-length item completes at once with value zero
                        if ((word_in.data & TAG_MASK) == PAGE_TAG && usage_page == '0) begin
                            found_next = 1'b1;
                        end
                        len_next   = 3'd0;
                        page_next  = 1'b0;
                        phase_next = PH_PREFIX;
                    end else begin
                        len_next   = (word_in.data[1:0] == SIZE_CODE_FOUR) ? 3'd4
                                   : {1'b0, word_in.data[1:0]};
                        page_next  = ((word_in.data & TAG_MASK) == PAGE_TAG);
                        phase_next = PH_SHORT_DATA;
                    end
                end
            end
            PH_LONG_SIZE: begin
                left_next  = word_in.data;
                phase_next = PH_LONG_TAG;
            end
            PH_LONG_TAG: begin
                phase_next = (left_reg == 8'd0) ? PH_PREFIX : PH_LONG_DATA;
            end
            PH_LONG_DATA: begin
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1) begin
                    phase_next = PH_PREFIX;
                end
            end
            PH_SHORT_DATA: begin
                pos_next   = pos_reg + 2'd1;
                value_next = value_acc;
                len_next   = len_dec;
                if (len_dec == 3'd0) begin
                    if (page_reg && value_acc == {{(ValueWidth-PageWidth){1'b0}}, usage_page}) begin
                        found_next = 1'b1;
                    end
                    phase_next = PH_PREFIX;
                    pos_next   = 2'd0;
                    value_next = '0;
                    page_next  = 1'b0;
                end
            end
            default: begin
                phase_next = PH_PREFIX;
            end
        endcase
    end

    assign found_now = found_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            left_reg  <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            value_reg <= '0;
            page_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else if (word_in.take) begin
            if (word_in.last) begin
                phase_reg <= PH_PREFIX;
                left_reg  <= '0;
                len_reg   <= '0;
                pos_reg   <= '0;
                value_reg <= '0;
                page_reg  <= 1'b0;
                found_reg <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                len_reg   <= len_next;
                pos_reg   <= pos_next;
                value_reg <= value_next;
                page_reg  <= page_next;
                found_reg <= found_next;
            end
        end
    end

    `ASSERT_NEXT(a_clear_on_last, aclk, aresetn, word_in.take && word_in.last, phase_reg == PH_PREFIX && !found_reg)
    `ASSERT_IMPL(a_short_len_live, aclk, aresetn, phase_reg == PH_SHORT_DATA, len_reg != 3'd0)
    `ASSERT_NEXT(a_found_sticky, aclk, aresetn, found_reg && !(word_in.take && word_in.last), found_reg)

endmodule

`default_nettype wire

// File: rtl/hid_descriptor_usage_page_scan_core.sv
// Scans a HID report descriptor for a Usage Page item equal to the page held in the
// configuration register. One descriptor byte is taken per cycle while no result is
// held back by m_ready; each word passes an input register, the item parser updates
// its state from it, and the word marked last loads the result register with the
// found flag, so a result passes the input register and then the result register.
// Long items are skipped, truncated items never match, and the parser clears itself
// after every last byte. Write the page only while no descriptor is in flight.
`default_nettype none

`include "assert_macros.svh"

module hid_descriptor_usage_page_scan_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [hidups_pkg::PageWidth-1:0]  cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_desc_byte,
    input  wire logic                              s_last_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_page_found
);
    import hidups_pkg::*;

    logic [PageWidth-1:0] usage_page_reg;
    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 m_valid_reg, m_valid_next;
    logic                 page_found_reg;
    logic                 out_free;
    logic                 take;
    logic                 found_now;
    parse_in_t            parse_word;

    assign out_free = !m_valid_reg || m_ready;
    assign take     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign parse_word.take = take;
    assign parse_word.last = in_last_reg;
    assign parse_word.data = in_byte_reg;

    hidups_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_in    (parse_word),
        .usage_page (usage_page_reg),
        .found_now  (found_now)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = in_last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usage_page_reg <= '0;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                usage_page_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_desc_byte;
            in_last_reg <= s_last_byte;
        end
        if (take && in_last_reg) begin
            page_found_reg <= found_now;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_page_found = page_found_reg;

    `ASSERT_NEXT(a_no_result_mid, aclk, aresetn, take && !in_last_reg, !m_valid)
    `ASSERT_NEXT(a_result_on_last, aclk, aresetn, take && in_last_reg, m_valid)
    `ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && m_valid_reg && !m_ready)

endmodule

`default_nettype wire
